// ===== rtl/column_scan_box_placer_defines.svh =====
// Assertion helpers for the column scan box placer.
// Both expect clk and arst_n in the scope where they are used.
`ifndef COLUMN_SCAN_BOX_PLACER_DEFINES_SVH
`define COLUMN_SCAN_BOX_PLACER_DEFINES_SVH

// Condition checked at every clock edge outside reset.
`define CSBP_ASSERT_NOW(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequence checked in the cycle after the antecedent.
`define CSBP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/csbp_pkg.sv =====
package csbp_pkg;

	localparam int unsigned MAX_BOXES_DEF = 64;
	localparam int unsigned COORD_W = 9;
	localparam int unsigned APB_AW = 4;
	localparam int unsigned APB_DW = 32;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_START_X = 2'd0;
	localparam logic [1:0] REG_COLUMN_STEP = 2'd1;
	localparam logic [1:0] REG_ROW_STEP = 2'd2;

	localparam logic [COORD_W-1:0] START_X_RST = 9'd4;
	localparam logic [COORD_W-1:0] COLUMN_STEP_RST = 9'd8;
	localparam logic [COORD_W-1:0] ROW_STEP_RST = 9'd8;

	typedef struct packed {
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] column_step;
		logic [COORD_W-1:0] row_step;
	} csbp_cfg_t;

	typedef struct packed {
		logic load;
		logic fail;
		logic place;
		logic scan_first;
		logic scan_run;
		logic advance;
		logic emit;
	} csbp_cmd_t;

	typedef struct packed {
		logic failed;
		logic full;
		logic empty;
		logic bounds_ok;
		logic hit;
		logic clear_done;
		logic x_over;
	} csbp_stat_t;

	// stored box: left edge, bottom edge in half units, width, height
	typedef struct packed {
		logic [8:0] x;
		logic [9:0] y2;
		logic [8:0] w;
		logic [8:0] h;
	} csbp_entry_t;

endpackage

// ===== rtl/csbp_regs.sv =====
module csbp_regs import csbp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output csbp_cfg_t         cfg
);

	csbp_cfg_t cfg_q;
	logic      wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_x     <= START_X_RST;
			cfg_q.column_step <= COLUMN_STEP_RST;
			cfg_q.row_step    <= ROW_STEP_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_START_X:     cfg_q.start_x     <= pwdata[COORD_W-1:0];
				REG_COLUMN_STEP: cfg_q.column_step <= pwdata[COORD_W-1:0];
				REG_ROW_STEP:    cfg_q.row_step    <= pwdata[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_START_X:     prdata = APB_DW'(cfg_q.start_x);
			REG_COLUMN_STEP: prdata = APB_DW'(cfg_q.column_step);
			REG_ROW_STEP:    prdata = APB_DW'(cfg_q.row_step);
			default:         prdata = '0;
		endcase
	end

endmodule

// ===== rtl/csbp_dp.sv =====
module csbp_dp import csbp_pkg::*; #(
	parameter int unsigned MAX_BOXES = MAX_BOXES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  csbp_cfg_t          cfg,
	input  csbp_cmd_t          cmd,
	input  logic               new_layout,
	input  logic [COORD_W-1:0] box_width,
	input  logic [COORD_W-1:0] box_height,
	output csbp_stat_t         stat,
	output logic               out_placed,
	output logic [COORD_W-1:0] out_left_x,
	output logic [COORD_W-1:0] out_center_y
);

	localparam int unsigned AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int unsigned CW = $clog2(MAX_BOXES + 1);
	localparam logic signed [10:0] Y_TOP = 11'sd400;
	localparam logic signed [10:0] Y_BOTTOM = -11'sd400;

	logic [9:0]         x_q;
	logic signed [10:0] y_q;
	logic [8:0]         w_q;
	logic [8:0]         h_q;
	logic [CW-1:0]      count_q;
	logic               failed_q;
	logic [CW-1:0]      rd_idx_q;

	csbp_entry_t mem [MAX_BOXES];
	csbp_entry_t rdata_s1;
	logic        rvalid_s1;
	logic        rlast_s1;

	logic       res_placed_q;
	logic [8:0] res_x_q;
	logic [8:0] res_y_q;
	logic       out_placed_q;
	logic [8:0] out_x_q;
	logic [8:0] out_y_q;

	logic signed [11:0] bot2;
	logic signed [11:0] top2;
	logic [10:0]        right;
	logic [8:0]         cand_x;
	logic [9:0]         cand_y2;
	logic [9:0]         cand_h2;
	logic               ox;
	logic               oy;
	logic               overlap;
	logic               issue;
	logic [CW-1:0]      issue_idx;
	logic [8:0]         rs;
	logic [8:0]         cs;
	logic signed [10:0] y_dec;
	csbp_entry_t        new_entry;

	// candidate edges; vertical edges in half units
	assign bot2  = $signed({y_q, 1'b0}) - $signed({3'b000, h_q});
	assign top2  = $signed({y_q, 1'b0}) + $signed({3'b000, h_q});
	assign right = {1'b0, x_q} + {2'b00, w_q};

	assign cand_x  = x_q[8:0];
	assign cand_y2 = bot2[9:0];
	assign cand_h2 = {h_q, 1'b0};

	// strict overlap against the entry read last cycle
	always_comb begin
		if (cand_x < rdata_s1.x)
			ox = ({1'b0, cand_x} + {1'b0, w_q}) > {1'b0, rdata_s1.x};
		else
			ox = ({1'b0, rdata_s1.x} + {1'b0, rdata_s1.w}) > {1'b0, cand_x};
		if (cand_y2 < rdata_s1.y2)
			oy = ({1'b0, cand_y2} + {1'b0, cand_h2}) > {1'b0, rdata_s1.y2};
		else
			oy = ({1'b0, rdata_s1.y2} + {1'b0, rdata_s1.h, 1'b0}) > {1'b0, cand_y2};
	end
	assign overlap = ox & oy;

	assign issue     = cmd.scan_first | (cmd.scan_run & (rd_idx_q < count_q));
	assign issue_idx = cmd.scan_first ? '0 : rd_idx_q;

	assign rs    = (cfg.row_step == '0) ? 9'd1 : cfg.row_step;
	assign cs    = (cfg.column_step == '0) ? 9'd1 : cfg.column_step;
	assign y_dec = y_q - $signed({2'b00, rs});

	assign new_entry.x  = cand_x;
	assign new_entry.y2 = cand_y2;
	assign new_entry.w  = w_q;
	assign new_entry.h  = h_q;

	assign stat.failed     = failed_q;
	assign stat.full       = count_q >= CW'(MAX_BOXES);
	assign stat.empty      = count_q == '0;
	assign stat.bounds_ok  = (x_q != '0) && (right < 11'd400) && (bot2 > 12'sd0)
		&& (top2 < 12'sd800);
	assign stat.hit        = rvalid_s1 & overlap;
	assign stat.clear_done = rvalid_s1 & rlast_s1 & ~overlap;
	assign stat.x_over     = x_q > 10'd400;

	assign out_placed   = out_placed_q;
	assign out_left_x   = out_x_q;
	assign out_center_y = out_y_q;

	always_ff @(posedge clk) begin
		if (cmd.place)
			mem[count_q[AW-1:0]] <= new_entry;
		if (issue)
			rdata_s1 <= mem[issue_idx[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			failed_q  <= 1'b0;
			rd_idx_q  <= '0;
			rvalid_s1 <= 1'b0;
			rlast_s1  <= 1'b0;
		end else begin
			rvalid_s1 <= issue;
			if (issue) begin
				rlast_s1 <= issue_idx == (count_q - CW'(1));
				rd_idx_q <= issue_idx + CW'(1);
			end
			if (cmd.load && new_layout) begin
				count_q  <= '0;
				failed_q <= 1'b0;
			end
			if (cmd.fail)
				failed_q <= 1'b1;
			if (cmd.place)
				count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= {1'b0, cfg.start_x};
			y_q <= Y_TOP;
			w_q <= box_width;
			h_q <= box_height;
		end else if (cmd.advance) begin
			if (y_dec < Y_BOTTOM) begin
				y_q <= Y_TOP;
				x_q <= x_q + {1'b0, cs};
			end else begin
				y_q <= y_dec;
			end
		end
		if (cmd.fail) begin
			res_placed_q <= 1'b0;
			res_x_q      <= '0;
			res_y_q      <= '0;
		end else if (cmd.place) begin
			res_placed_q <= 1'b1;
			res_x_q      <= cand_x;
			res_y_q      <= y_q[8:0];
		end
		if (cmd.emit) begin
			out_placed_q <= res_placed_q;
			out_x_q      <= res_x_q;
			out_y_q      <= res_y_q;
		end
	end

endmodule

// ===== rtl/csbp_ctrl.sv =====
module csbp_ctrl import csbp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  logic       m_tready,
	input  csbp_stat_t stat,
	output csbp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		IDLE,
		START,
		CAND,
		SCAN,
		ADV,
		FIN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   m_tvalid_q;
	logic   out_free;

	assign s_tready = state_q == IDLE;
	assign m_tvalid = m_tvalid_q;
	assign out_free = ~m_tvalid_q | m_tready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = START;
				end
			end
			START: begin
				if (stat.failed || stat.full) begin
					cmd.fail = 1'b1;
					state_d  = FIN;
				end else begin
					state_d = CAND;
				end
			end
			CAND: begin
				if (!stat.bounds_ok) begin
					state_d = ADV;
				end else if (stat.empty) begin
					cmd.place = 1'b1;
					state_d   = FIN;
				end else begin
					cmd.scan_first = 1'b1;
					state_d        = SCAN;
				end
			end
			SCAN: begin
				if (stat.hit) begin
					state_d = ADV;
				end else if (stat.clear_done) begin
					cmd.place = 1'b1;
					state_d   = FIN;
				end else begin
					cmd.scan_run = 1'b1;
				end
			end
			ADV: begin
				if (stat.x_over) begin
					cmd.fail = 1'b1;
					state_d  = FIN;
				end else begin
					cmd.advance = 1'b1;
					state_d     = CAND;
				end
			end
			FIN: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = IDLE;
				end
			end
			default: state_d = IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/column_scan_box_placer.sv =====
// Flow from beat accepted to result valid: a box is refused at once if the layout has failed
// or the store is full; otherwise candidates are tried in turn, each one outside the square or
// overlapping a stored box is skipped, and the first clear one is placed (at once if empty).
// Throughput: one box at a time, one stored box compared per cycle; unit steps give up to
// about 320000 candidates; a result waits in the output register.
// Reset (arst_n low, asynchronous): store empty, failure flag clear, registers to defaults.
`include "column_scan_box_placer_defines.svh"

module column_scan_box_placer import csbp_pkg::*; #(
	parameter int unsigned MAX_BOXES = MAX_BOXES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [23:0]       s_tdata,  // [8:0] box_width, [17:9] box_height
	input  logic              s_tuser,  // [0] new_layout
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,  // [8:0] left_x, [17:9] center_y
	output logic              m_tuser,  // [0] placed
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	csbp_cfg_t          cfg;
	csbp_cmd_t          cmd;
	csbp_stat_t         stat;
	logic [COORD_W-1:0] left_x;
	logic [COORD_W-1:0] center_y;
	logic               out_in_square;

	csbp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	csbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	csbp_dp #(
		.MAX_BOXES (MAX_BOXES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.new_layout   (s_tuser),
		.box_width    (s_tdata[8:0]),
		.box_height   (s_tdata[17:9]),
		.stat         (stat),
		.out_placed   (m_tuser),
		.out_left_x   (left_x),
		.out_center_y (center_y)
	);

	assign m_tdata = {6'b000000, center_y, left_x};

	assign out_in_square = (left_x < 9'd400) && (center_y != 9'd0) && (center_y < 9'd400);

	`CSBP_ASSERT_NOW(a_no_write_when_full, !(stat.full && cmd.place), "write into full box store")
	`CSBP_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "beat taken while busy")
	`CSBP_ASSERT_NOW(a_placed_inside, !(m_tvalid && m_tuser) || out_in_square, "box outside square")
	`CSBP_ASSERT_NOW(a_fail_zero, !(m_tvalid && !m_tuser) || m_tdata == 24'd0, "fail with position")

endmodule
